### design/deh_pkg.sv
// Shared types and constants of the depth error heatmap.
`default_nettype none
package deh_pkg;

  localparam int unsigned DefMaxPixels = 1048576;
  localparam logic [15:0] DefFarCutoff = 16'd9000;
  localparam logic [15:0] DefErrorScale = 16'd40;
  localparam int unsigned ColorSteps = 8;
  localparam int unsigned MseSteps = 60;
  localparam int unsigned StepW = 6;
  localparam int unsigned CntW = 21;
  localparam int unsigned SumW = 52;
  localparam int unsigned MseW = 40;

  typedef enum logic [0:0] {
    REG_FAR_CUTOFF  = 1'b0,
    REG_ERROR_SCALE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] reference_depth;
    logic [15:0] rebuilt_depth;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    logic [15:0]     pixel_error;
    logic            pixel_ok;
    logic            stats_ready;
    logic [15:0]     peak_error;
    logic [SumW-1:0] square_sum;
    logic [CntW-1:0] good_count;
    logic [MseW-1:0] mean_square_q8;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic setup;
    logic color_step;
    logic mse_load;
    logic mse_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/deh_ctrl.sv
// Controller state machine of the depth error heatmap.
`default_nettype none
module deh_ctrl
  import deh_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_COLOR  = 7'b0001000,
    ST_MSE_LD = 7'b0010000,
    ST_MSE    = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        step_d = '0;
        state_d = ST_COLOR;
      end
      ST_COLOR: begin
        cmd_o.color_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(ColorSteps - 1)) begin
          state_d = sts_i.last ? ST_MSE_LD : ST_OUT;
        end
      end
      ST_MSE_LD: begin
        cmd_o.mse_load = 1'b1;
        step_d = '0;
        state_d = ST_MSE;
      end
      ST_MSE: begin
        cmd_o.mse_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(MseSteps - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_load_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> state_q == ST_EVAL) else $error("load not followed by eval");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free) else $error("output overwritten");
  a_color_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLOR && step_q == StepW'(ColorSteps - 1))
    |=> (state_q == ST_MSE_LD || state_q == ST_OUT)) else $error("color division overrun");
`endif

endmodule
`default_nettype wire

### design/deh_datapath.sv
// Datapath: error, color division, frame statistics and mean square division.
`default_nettype none
module deh_datapath
  import deh_pkg::*;
#(
  parameter int unsigned MaxPixels = DefMaxPixels
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_item_t    in_data_i,
  input  logic [15:0] far_cutoff_i,
  input  logic [15:0] error_scale_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output out_item_t   out_data_o
);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] CntCap =
    (MaxPixels < (2 ** CntW - 1)) ? CntW'(MaxPixels) : CntMax;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam int unsigned DivW = SumW + 8;

  logic [15:0] ref_q, rec_q;
  logic        last_q;
  logic [15:0] e_q;
  logic        ok_q;
  logic [31:0] sq_q;
  logic [15:0] peak_q;
  logic [SumW-1:0] acc_q;
  logic [CntW-1:0] cnt_q;
  logic [15:0] rem_q [3];
  logic [7:0]  quo_q [3];
  logic [2:0]  cflag_q;
  logic [7:0]  cval_q [3];
  logic [DivW-1:0] mdiv_q;
  logic [CntW-1:0] mrem_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [15:0] rec_z, diff, s;
  logic        ok_c;
  logic [17:0] e4, s1, s2, s3, s4;
  logic [17:0] tr, tg, tb;
  logic [23:0] num [3];
  logic [2:0]  cflag_d;
  logic [7:0]  cval_d [3];
  logic        mag;
  logic [SumW:0] acc_sum;
  logic [CntW:0] mt;
  logic          mge;
  out_item_t     out_d;

  assign s = (error_scale_i == 16'd0) ? 16'd1 : error_scale_i;
  assign rec_z = (rec_q > far_cutoff_i) ? 16'd0 : rec_q;
  assign ok_c = (ref_q != 16'd0) && (rec_z < far_cutoff_i);
  assign diff = (ref_q > rec_z) ? (ref_q - rec_z) : (rec_z - ref_q);

  assign e4 = {e_q, 2'b00};
  assign s1 = {2'b00, s};
  assign s2 = {1'b0, s, 1'b0};
  assign s3 = s1 + s2;
  assign s4 = {s, 2'b00};
  assign mag = ({2'b00, e_q} > s1);
  assign tr = s2 - e4;
  assign tg = (e4 <= s1) ? e4 : (s4 - e4);
  assign tb = e4 - s2;
  assign num[0] = 24'({tb, 8'd0} - {8'd0, tb});
  assign num[1] = 24'({tg, 8'd0} - {8'd0, tg});
  assign num[2] = 24'({tr, 8'd0} - {8'd0, tr});

  always_comb begin
    cflag_d = 3'b111;
    cval_d[0] = 8'd0;
    cval_d[1] = 8'd0;
    cval_d[2] = 8'd0;
    if (mag) begin
      cval_d[0] = 8'd255;
      cval_d[2] = 8'd255;
    end else begin
      if ({e_q, 1'b0} <= s1[16:0]) begin
        cval_d[0] = 8'd0;
      end else if (e4 <= s3) begin
        cflag_d[0] = 1'b0;
      end else begin
        cval_d[0] = 8'd255;
      end
      if (e4 <= s1) begin
        cflag_d[1] = 1'b0;
      end else if (e4 <= s3) begin
        cval_d[1] = 8'd255;
      end else begin
        cflag_d[1] = 1'b0;
      end
      if (e4 <= s1) begin
        cval_d[2] = 8'd255;
      end else if (e4 <= s2) begin
        cflag_d[2] = 1'b0;
      end else begin
        cval_d[2] = 8'd0;
      end
    end
  end

  assign acc_sum = {1'b0, acc_q} + {{(SumW - 31){1'b0}}, sq_q};
  assign mt = {mrem_q, mdiv_q[DivW-1]};
  assign mge = (mt >= {1'b0, cnt_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ref_q <= in_data_i.reference_depth;
      rec_q <= in_data_i.rebuilt_depth;
      last_q <= in_data_i.frame_end;
    end
    if (cmd_i.eval) begin
      ok_q <= ok_c;
      e_q <= ok_c ? diff : 16'd0;
      sq_q <= ok_c ? (diff * diff) : 32'd0;
    end
    if (cmd_i.setup) begin
      cflag_q <= cflag_d;
      for (int i = 0; i < 3; i++) begin
        cval_q[i] <= cval_d[i];
        rem_q[i] <= num[i][23:8];
        quo_q[i] <= num[i][7:0];
      end
    end
    if (cmd_i.color_step) begin
      for (int i = 0; i < 3; i++) begin
        if ({rem_q[i], quo_q[i][7]} >= {1'b0, s}) begin
          rem_q[i] <= 16'({rem_q[i], quo_q[i][7]} - {1'b0, s});
          quo_q[i] <= {quo_q[i][6:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][14:0], quo_q[i][7]};
          quo_q[i] <= {quo_q[i][6:0], 1'b0};
        end
      end
    end
    if (cmd_i.mse_load) begin
      mdiv_q <= {acc_q, 8'd0};
      mrem_q <= '0;
    end
    if (cmd_i.mse_step) begin
      mrem_q <= mge ? CntW'(mt - {1'b0, cnt_q}) : mt[CntW-1:0];
      mdiv_q <= {mdiv_q[DivW-2:0], mge};
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d = '0;
    out_d.blue = ok_q ? (cflag_q[0] ? cval_q[0] : quo_q[0]) : 8'd0;
    out_d.green = ok_q ? (cflag_q[1] ? cval_q[1] : quo_q[1]) : 8'd0;
    out_d.red = ok_q ? (cflag_q[2] ? cval_q[2] : quo_q[2]) : 8'd0;
    out_d.pixel_error = e_q;
    out_d.pixel_ok = ok_q;
    out_d.stats_ready = last_q;
    if (last_q) begin
      out_d.peak_error = peak_q;
      out_d.square_sum = acc_q;
      out_d.good_count = cnt_q;
      if (cnt_q == '0) begin
        out_d.mean_square_q8 = '0;
      end else if (mdiv_q[DivW-1:MseW] != '0) begin
        out_d.mean_square_q8 = {MseW{1'b1}};
      end else begin
        out_d.mean_square_q8 = mdiv_q[MseW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.setup && ok_q) begin
        acc_q <= acc_sum[SumW] ? SumMax : acc_sum[SumW-1:0];
        if (cnt_q < CntCap) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (e_q > peak_q) begin
          peak_q <= e_q;
        end
      end else if (cmd_i.out_load && last_q) begin
        peak_q <= '0;
        acc_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.last = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

### design/depth_error_heatmap.sv
// Top level of the depth error heatmap with frame statistics.
//
// Input channel: in_valid_i / in_ready_o with one pixel item, a reference
// and a reconstructed depth plus a frame end flag. Output channel:
// out_valid_o / out_ready_i, one result item per pixel: jet color, error,
// valid flag and, on the frame's last pixel, peak error, sum of squares,
// valid count and mean square error in Q.8.
// One pixel is in work at a time. From acceptance to its result in the
// output register a pixel passes error and square, setup, and 8 steps
// of the three parallel color dividers. The last pixel of a frame then
// also passes the bit-serial mean square divider.
// A new pixel is taken once the previous result is loaded into the output
// register, so one result may wait there while the next pixel is at work.
// If the receiver stalls, the block holds the finished result and waits.
// Reset clears the statistics and the output valid flag; far_cutoff comes
// up as 9000 and error_scale as 40. Registers sit on the APB port at byte
// offsets 0 and 4; write them only while no pixel is in work.
`default_nettype none
module depth_error_heatmap
  import deh_pkg::*;
#(
  parameter int unsigned MaxPixels = DefMaxPixels
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output out_item_t   out_data_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] far_cutoff_q, error_scale_q;
  cmd_t cmd;
  sts_t sts;
  reg_idx_e widx;

  assign pready = 1'b1;
  assign widx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_cutoff_q <= DefFarCutoff;
      error_scale_q <= DefErrorScale;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_FAR_CUTOFF: far_cutoff_q <= pwdata[15:0];
        REG_ERROR_SCALE: error_scale_q <= pwdata[15:0];
        default: far_cutoff_q <= far_cutoff_q;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_FAR_CUTOFF: prdata = {16'd0, far_cutoff_q};
      REG_ERROR_SCALE: prdata = {16'd0, error_scale_q};
      default: prdata = '0;
    endcase
  end

  deh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deh_datapath #(
    .MaxPixels (MaxPixels)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (in_data_i),
    .far_cutoff_i  (far_cutoff_q),
    .error_scale_i (error_scale_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule
`default_nettype wire
